// ===== hdl/tcf_pkg.sv =====
// ----------------------------------------------------------------------------
// tcf_pkg
// Shared constants, types and the CORDIC angle table of the tilt filter.
// ----------------------------------------------------------------------------
package tcf_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ANGLE_FRAC_DEF   = 16;
   localparam int TABLE_FRAC       = 24;

   localparam int X_W     = 36;
   localparam int Z_W     = 34;
   localparam int MAG_W   = 31;
   localparam int DEN_W   = 26;
   localparam int QUO_W   = 52;
   localparam int PROP_W  = 54;
   localparam int DIFF_W  = 55;
   localparam int LO_W    = 28;
   localparam int PLO_W   = 45;
   localparam int SUM_W   = 76;
   localparam int ACC_W   = 32;
   localparam int BLEND_W = 17;
   localparam int SCALE_W = 16;
   localparam int CSR_IDX_W = 4;
   localparam int Q_DEPTH = 2;

   localparam logic [CSR_IDX_W-1:0] REG_BLEND = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE = 4'd1;

   localparam logic [BLEND_W-1:0] BLEND_RESET = 17'd1311;
   localparam logic [BLEND_W-1:0] BLEND_ONE   = 17'd65536;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd131;

   typedef logic [1:0] cls_type;
   localparam cls_type CLS_CORDIC = 2'd0;
   localparam cls_type CLS_ZERO   = 2'd1;
   localparam cls_type CLS_POS90  = 2'd2;
   localparam cls_type CLS_NEG90  = 2'd3;

   typedef struct packed {
      logic signed [15:0] ax;
      logic [16:0]        az_mag;
      logic               gy_neg;
      logic [MAG_W-1:0]   mag;
      cls_type            cls;
   } item_type;

   function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] i);
      logic signed [Z_W-1:0] v;
      case (i)
         5'd0:  v = 34'sd754974720;
         5'd1:  v = 34'sd445687602;
         5'd2:  v = 34'sd235489088;
         5'd3:  v = 34'sd119537938;
         5'd4:  v = 34'sd60000934;
         5'd5:  v = 34'sd30029717;
         5'd6:  v = 34'sd15018523;
         5'd7:  v = 34'sd7509720;
         5'd8:  v = 34'sd3754917;
         5'd9:  v = 34'sd1877466;
         5'd10: v = 34'sd938734;
         5'd11: v = 34'sd469367;
         5'd12: v = 34'sd234684;
         5'd13: v = 34'sd117342;
         5'd14: v = 34'sd58671;
         5'd15: v = 34'sd29335;
         5'd16: v = 34'sd14668;
         5'd17: v = 34'sd7334;
         5'd18: v = 34'sd3667;
         5'd19: v = 34'sd1833;
         5'd20: v = 34'sd917;
         5'd21: v = 34'sd458;
         5'd22: v = 34'sd229;
         5'd23: v = 34'sd115;
         5'd24: v = 34'sd57;
         5'd25: v = 34'sd29;
         5'd26: v = 34'sd14;
         5'd27: v = 34'sd7;
         5'd28: v = 34'sd4;
         5'd29: v = 34'sd2;
         5'd30: v = 34'sd1;
         default: v = 34'sd0;
      endcase
      return v;
   endfunction

endpackage

// ===== hdl/tcf_if.sv =====
// ----------------------------------------------------------------------------
// tcf channel interfaces
// Request, response and register write channels of the tilt filter.
// ----------------------------------------------------------------------------
interface tcf_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_z;
   logic signed [15:0] gyro_y;
   logic [15:0]        elapsed_ms;
   modport source (output valid, accel_x, accel_z, gyro_y, elapsed_ms, input ready);
   modport sink (input valid, accel_x, accel_z, gyro_y, elapsed_ms, output ready);
endinterface

interface tcf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] tilt_angle;
   logic signed [23:0] accel_angle;
   modport source (output valid, tilt_angle, accel_angle, input ready);
   modport sink (input valid, tilt_angle, accel_angle, output ready);
endinterface

interface tcf_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [16:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/tilt_complementary_filter.sv =====
// ----------------------------------------------------------------------------
// tilt_complementary_filter
// Complementary tilt filter: CORDIC accelerometer tilt blended with the
// integrated gyro rate into one saturated angle register.
//
//  channel   direction  handshake       payload
//  req_ch    in         valid / ready   accel_x, accel_z, gyro_y, elapsed_ms
//  rsp_ch    out        valid / ready   tilt_angle, accel_angle
//  csr_ch    in         valid / ready   index, data
//
// the back end runs the CORDIC steps of a request alongside the
// one-bit-per-cycle divider that forms its gyro increment
// the front takes a request per cycle into a two-entry queue while it is not full
// reset clears the angle register, the registers to their defaults, the queue
// a held response stalls the back end; the front keeps filling the queue
// ----------------------------------------------------------------------------
module tilt_complementary_filter #(
   parameter int CORDIC_STEPS    = tcf_pkg::CORDIC_STEPS_DEF,
   parameter int ANGLE_FRAC_BITS = tcf_pkg::ANGLE_FRAC_DEF
) (
   input  logic       clock,
   input  logic       reset,
   tcf_req_if.sink    req_ch,
   tcf_rsp_if.source  rsp_ch,
   tcf_csr_if.sink    csr_ch
);
   import tcf_pkg::*;

   logic [BLEND_W-1:0] blend_ff, blend_in;
   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic               q_full, q_push, q_pop, q_valid;
   item_type           push_item, pop_item;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      blend_in = blend_ff;
      scale_in = scale_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_BLEND: blend_in = csr_ch.data;
            REG_SCALE: scale_in = csr_ch.data[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_ff <= BLEND_RESET;
         scale_ff <= SCALE_RESET;
      end else begin
         blend_ff <= blend_in;
         scale_ff <= scale_in;
      end
   end

   tcf_front u_front (
      .req_ch (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_item (push_item)
   );

   tcf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .item      (pop_item)
   );

   tcf_back #(
      .CORDIC_STEPS    (CORDIC_STEPS),
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_item  (pop_item),
      .q_pop   (q_pop),
      .blend   (blend_ff),
      .scale   (scale_ff),
      .rsp_ch  (rsp_ch)
   );

endmodule

// ===== hdl/tcf_front.sv =====
// ----------------------------------------------------------------------------
// tcf_front
// Accepts requests, classifies the tilt case and forms the gyro magnitude.
// ----------------------------------------------------------------------------
module tcf_front (
   tcf_req_if.sink            req_ch,
   input  logic               q_full,
   output logic               q_push,
   output tcf_pkg::item_type  q_item
);
   import tcf_pkg::*;

   logic [15:0] gy_abs;
   logic [31:0] prod;

   assign req_ch.ready = !q_full;
   assign q_push       = req_ch.valid && !q_full;

   always_comb begin
      gy_abs        = req_ch.gyro_y[15] ? 16'(-req_ch.gyro_y) : 16'(req_ch.gyro_y);
      prod          = 32'(gy_abs) * 32'(req_ch.elapsed_ms);
      q_item.ax     = req_ch.accel_x;
      q_item.az_mag = req_ch.accel_z[15] ? 17'(-18'(req_ch.accel_z))
                                         : 17'(req_ch.accel_z);
      q_item.gy_neg = req_ch.gyro_y[15];
      q_item.mag    = prod[MAG_W-1:0];
      if (req_ch.accel_x == 16'sd0) begin
         q_item.cls = CLS_ZERO;
      end else if (req_ch.accel_z == 16'sd0) begin
         q_item.cls = req_ch.accel_x[15] ? CLS_NEG90 : CLS_POS90;
      end else begin
         q_item.cls = CLS_CORDIC;
      end
   end

endmodule

// ===== hdl/tcf_queue.sv =====
// ----------------------------------------------------------------------------
// tcf_queue
// Short request queue between the front and the back of the filter.
// ----------------------------------------------------------------------------
module tcf_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tcf_pkg::item_type  push_item,
   output logic               full,
   input  logic               pop,
   output logic               valid,
   output tcf_pkg::item_type  item
);
   import tcf_pkg::*;

   localparam int PTR_W = $clog2(Q_DEPTH);

   item_type         mem_ff [Q_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0]   cnt_ff, cnt_in;

   assign full  = cnt_ff == (PTR_W+1)'(Q_DEPTH);
   assign valid = cnt_ff != '0;
   assign item  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? PTR_W'((32'(wr_ff) + 1) % Q_DEPTH) : wr_ff;
      rd_in  = pop ? PTR_W'((32'(rd_ff) + 1) % Q_DEPTH) : rd_ff;
      cnt_in = cnt_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule

// ===== hdl/tcf_back.sv =====
// ----------------------------------------------------------------------------
// tcf_back
// Sequencer: CORDIC tilt, gyro increment divider, blend and saturation.
// ----------------------------------------------------------------------------
module tcf_back #(
   parameter int CORDIC_STEPS    = tcf_pkg::CORDIC_STEPS_DEF,
   parameter int ANGLE_FRAC_BITS = tcf_pkg::ANGLE_FRAC_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  tcf_pkg::item_type             q_item,
   output logic                          q_pop,
   input  logic [tcf_pkg::BLEND_W-1:0]   blend,
   input  logic [tcf_pkg::SCALE_W-1:0]   scale,
   tcf_rsp_if.source                     rsp_ch
);
   import tcf_pkg::*;

   localparam int NW    = 32 + ANGLE_FRAC_BITS;
   localparam int CNT_W = $clog2(NW);
   localparam int SH    = TABLE_FRAC - ANGLE_FRAC_BITS;
   localparam logic signed [Z_W-1:0] Z_HALF = Z_W'(64'sd1 <<< (SH - 1));
   localparam logic signed [Z_W-1:0] Z_FULL = Z_W'(64'sd90 <<< ANGLE_FRAC_BITS);
   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sd2147483647);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PREP = 3'd1;
   localparam logic [2:0] S_RUN  = 3'd2;
   localparam logic [2:0] S_ACC  = 3'd3;
   localparam logic [2:0] S_DIFF = 3'd4;
   localparam logic [2:0] S_MLO  = 3'd5;
   localparam logic [2:0] S_MHI  = 3'd6;
   localparam logic [2:0] S_SUM  = 3'd7;

   logic [2:0]                state_ff, state_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   item_type                  item_ff, item_in;
   logic signed [X_W-1:0]     x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0]     z_ff, z_in;
   logic [DEN_W-1:0]          den_ff, den_in;
   logic [NW-1:0]             num_ff, num_in;
   logic [DEN_W:0]            rem_ff, rem_in;
   logic [QUO_W-1:0]          quo_ff, quo_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [PROP_W-1:0]  prop_ff, prop_in;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic [PLO_W-1:0]          plo_ff, plo_in;
   logic signed [PLO_W-1:0]   phi_ff, phi_in;
   logic signed [31:0]        angle_ff, angle_in;
   logic                      out_valid_ff, out_valid_in;
   logic signed [31:0]        out_tilt_ff, out_tilt_in;
   logic signed [23:0]        out_acc_ff, out_acc_in;

   logic [BLEND_W-1:0]        a_eff;
   logic [SCALE_W-1:0]        scale_eff;
   logic [4:0]                sh;
   logic signed [X_W-1:0]     dx, dy;
   logic [DEN_W:0]            rem_sh;
   logic signed [Z_W-1:0]     z_rnd;
   logic signed [PROP_W-1:0]  inc;
   logic signed [SUM_W-1:0]   sum_raw, sum_sh;

   assign q_pop              = (state_ff == S_IDLE) && q_valid && !out_valid_ff;
   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.tilt_angle  = out_tilt_ff;
   assign rsp_ch.accel_angle = out_acc_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      item_in      = item_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      den_in       = den_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      acc_in       = acc_ff;
      prop_in      = prop_ff;
      diff_in      = diff_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      angle_in     = angle_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_tilt_in  = out_tilt_ff;
      out_acc_in   = out_acc_ff;

      a_eff     = (blend > BLEND_ONE) ? BLEND_ONE : blend;
      scale_eff = (scale == '0) ? SCALE_W'(1) : scale;
      sh        = cnt_ff[4:0];
      dx        = y_ff >>> sh;
      dy        = x_ff >>> sh;
      rem_sh    = {rem_ff[DEN_W-1:0], num_ff[CNT_W'(NW - 1) - cnt_ff]};
      z_rnd     = (z_ff + Z_HALF) >>> SH;
      inc       = item_ff.gy_neg ? -PROP_W'(quo_ff) : PROP_W'(quo_ff);
      sum_raw   = (SUM_W'(prop_ff) <<< 16) + SUM_W'(plo_ff)
                + (SUM_W'(phi_ff) <<< LO_W) + SUM_W'(32768);
      sum_sh    = sum_raw >>> 16;

      unique case (state_ff)
         S_IDLE: begin
            if (q_pop) begin
               item_in  = q_item;
               x_in     = X_W'({q_item.az_mag, 16'h0000});
               y_in     = X_W'($signed({q_item.ax, 16'h0000}));
               z_in     = '0;
               den_in   = DEN_W'(scale_eff) * DEN_W'(1000);
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            num_in   = (NW'(item_ff.mag) << ANGLE_FRAC_BITS) + NW'(den_ff >> 1);
            rem_in   = '0;
            quo_in   = '0;
            cnt_in   = '0;
            state_in = S_RUN;
         end
         S_RUN: begin
            if (32'(cnt_ff) < CORDIC_STEPS) begin
               if (!y_ff[X_W-1]) begin
                  x_in = x_ff + dx;
                  y_in = y_ff - dy;
                  z_in = z_ff + atan_entry(sh);
               end else begin
                  x_in = x_ff - dx;
                  y_in = y_ff + dy;
                  z_in = z_ff - atan_entry(sh);
               end
            end
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in = rem_sh - {1'b0, den_ff};
               quo_in = {quo_ff[QUO_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[QUO_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NW - 1)) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            case (item_ff.cls)
               CLS_ZERO:  acc_in = '0;
               CLS_POS90: acc_in = ACC_W'(Z_FULL);
               CLS_NEG90: acc_in = ACC_W'(-Z_FULL);
               default: begin
                  if (z_rnd > Z_FULL) begin
                     acc_in = ACC_W'(Z_FULL);
                  end else if (z_rnd < -Z_FULL) begin
                     acc_in = ACC_W'(-Z_FULL);
                  end else begin
                     acc_in = ACC_W'(z_rnd);
                  end
               end
            endcase
            prop_in  = PROP_W'(angle_ff) + inc;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            diff_in  = DIFF_W'(acc_ff) - DIFF_W'(prop_ff);
            state_in = S_MLO;
         end
         S_MLO: begin
            plo_in   = PLO_W'(a_eff) * PLO_W'(diff_ff[LO_W-1:0]);
            state_in = S_MHI;
         end
         S_MHI: begin
            phi_in   = PLO_W'($signed({1'b0, a_eff}))
                     * PLO_W'($signed(diff_ff[DIFF_W-1:LO_W]));
            state_in = S_SUM;
         end
         S_SUM: begin
            if (sum_sh > SAT_HI) begin
               angle_in = 32'(SAT_HI);
            end else if (sum_sh < -SAT_HI) begin
               angle_in = 32'(-SAT_HI);
            end else begin
               angle_in = 32'(sum_sh);
            end
            out_tilt_in  = angle_in;
            out_acc_in   = acc_ff[23:0];
            out_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         angle_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         angle_ff     <= angle_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      item_ff     <= item_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      den_ff      <= den_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      acc_ff      <= acc_in;
      prop_ff     <= prop_in;
      diff_ff     <= diff_in;
      plo_ff      <= plo_in;
      phi_ff      <= phi_in;
      out_tilt_ff <= out_tilt_in;
      out_acc_ff  <= out_acc_in;
   end

   a_sum_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUM) |=> out_valid_ff)
      else $error("result not presented after blend");

   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == S_IDLE) && q_valid && !out_valid_ff)
      else $error("queue popped while busy");

   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN) |-> (32'(cnt_ff) < NW))
      else $error("iteration count out of range");

   a_busy_no_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !q_pop)
      else $error("pop while a request is in flight");

endmodule
